### hw/rtl/agfm_pkg.sv
`default_nettype none
package agfm_pkg;

  localparam int NumChannels = 2;
  localparam int ChW         = (NumChannels > 1) ? $clog2(NumChannels) : 1;

  localparam int CountW = 24;
  localparam int FreqW  = 32;
  localparam int TickW  = 20;
  localparam int ElapW  = 24;
  localparam int RemW   = 25;
  localparam int GateW  = 24;

  // shared divider: divisor up to f + 64000 in Q24.8, 34 bits
  localparam int DivW  = 34;
  localparam int IterW = 6;

  localparam logic [IterW-1:0] FreqIters = IterW'(32);
  localparam logic [IterW-1:0] GateIters = IterW'(20);

  localparam logic [TickW-1:0] TickReset = TickW'(1000);
  localparam logic [ElapW-1:0] InitUs    = ElapW'(500000);

  localparam logic [GateW-1:0] GateLongUs  = GateW'(10000000);
  localparam logic [GateW-1:0] GateOneUs   = GateW'(1000000);
  localparam logic [GateW-1:0] GateShortUs = GateW'(10000);

  localparam logic [ElapW-1:0] ElapsedMax = {ElapW{1'b1}};

  // most negative remaining time, -16777216 us
  localparam logic signed [RemW-1:0] RemainMin = {1'b1, {(RemW-1){1'b0}}};

  // 0.97 Hz in Q24.8, last value that still takes the long gate
  localparam logic [FreqW-1:0] SlowFreqMax = FreqW'(248);

  // 256000000 = 125000 << 11
  localparam int                ScaleMulW  = 17;
  localparam logic [ScaleMulW-1:0] ScaleMul = ScaleMulW'(125000);
  localparam int                ProdW      = CountW + ScaleMulW;

  // 16384000000000 = 15625000 << 20, low part zero
  localparam logic [DivW-1:0] GateNumHi = DivW'(15625000);
  localparam logic [DivW-1:0] GateBias  = DivW'(16384000);

endpackage
`default_nettype wire

### hw/rtl/agfm_in_if.sv
`default_nettype none
interface agfm_in_if import agfm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CountW-1:0] count_ch0;
  logic [CountW-1:0] count_ch1;
  logic              restart_ch0;
  logic              restart_ch1;

  modport source (output valid, count_ch0, count_ch1, restart_ch0, restart_ch1,
                  input ready);
  modport sink (input valid, count_ch0, count_ch1, restart_ch0, restart_ch1,
                output ready);
endinterface
`default_nettype wire

### hw/rtl/agfm_out_if.sv
`default_nettype none
interface agfm_out_if import agfm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [FreqW-1:0] freq_ch0;
  logic [FreqW-1:0] freq_ch1;
  logic             updated_ch0;
  logic             updated_ch1;

  modport source (output valid, freq_ch0, freq_ch1, updated_ch0, updated_ch1,
                  input ready);
  modport sink (input valid, freq_ch0, freq_ch1, updated_ch0, updated_ch1,
                output ready);
endinterface
`default_nettype wire

### hw/rtl/adaptive_gate_frequency_meter.sv
// channel   dir   handshake          payload
// in_ch     in    valid/ready        count_ch0/1 (24b), restart_ch0/1
// out_ch    out   valid/ready        freq_ch0/1 (Q24.8, 32b), updated_ch0/1
// cfg       in    cfg_we_i           cfg_wdata_i = tick period in us (20b)
//
// one item at a time: a channel whose gate has not expired is passed over; when a
// gate expires, up to two divisions (frequency, then gate) run on the one shared
// shift-subtract divider, or a pending restart picks a short gate instead.
// the next item is taken while the previous result waits in the output register;
// the tick step stalls while that register still holds an item not yet taken.
// reset puts each channel at a 0.5 s gate already expired and tick period 1000 us.
`default_nettype none
module adaptive_gate_frequency_meter import agfm_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [TickW-1:0] cfg_wdata_i,
  agfm_in_if.sink               in_ch,
  agfm_out_if.source            out_ch
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHAN  = 3'd1;
  localparam logic [2:0] S_FPREP = 3'd2;
  localparam logic [2:0] S_FDIV  = 3'd3;
  localparam logic [2:0] S_GPREP = 3'd4;
  localparam logic [2:0] S_GDIV  = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;
  localparam logic [2:0] S_TICK  = 3'd7;

  logic [2:0]     state_q;
  logic [ChW-1:0] ch_q;
  logic [TickW-1:0] tick_q;

  logic [CountW-1:0]      count_q   [NumChannels];
  logic [ElapW-1:0]       elapsed_q [NumChannels];
  logic signed [RemW-1:0] remain_q  [NumChannels];
  logic [GateW-1:0]       gate_q    [NumChannels];
  logic [FreqW-1:0]       freq_q    [NumChannels];
  logic [NumChannels-1:0] expired_q;
  logic [NumChannels-1:0] pend_q;
  logic [NumChannels-1:0] upd_q;

  logic [ProdW-1:0] prod_q;
  logic [FreqW-1:0] res_q;

  logic [DivW-1:0]  rem_q;
  logic [DivW-1:0]  den_q;
  logic [FreqW-1:0] num_q;
  logic [FreqW-1:0] quo_q;
  logic [IterW-1:0] cnt_q;

  logic             out_valid_q;
  logic [FreqW-1:0] out_freq_q [NumChannels];
  logic [NumChannels-1:0] out_upd_q;

  logic [CountW-1:0]      count_in [NumChannels];
  logic [NumChannels-1:0] restart_in;
  logic                   in_acc;
  logic                   out_free;
  logic                   last_ch;

  assign count_in[0]   = in_ch.count_ch0;
  assign count_in[1]   = in_ch.count_ch1;
  assign restart_in    = {in_ch.restart_ch1, in_ch.restart_ch0};
  assign in_ch.ready   = (state_q == S_IDLE);
  assign in_acc        = in_ch.valid && in_ch.ready;
  assign out_free      = !out_valid_q || out_ch.ready;
  assign last_ch       = (ch_q == ChW'(NumChannels - 1));

  assign out_ch.valid       = out_valid_q;
  assign out_ch.freq_ch0    = out_freq_q[0];
  assign out_ch.freq_ch1    = out_freq_q[1];
  assign out_ch.updated_ch0 = out_upd_q[0];
  assign out_ch.updated_ch1 = out_upd_q[1];

  // shared divider step: one quotient bit per cycle
  logic [DivW:0]   div_shift;
  logic [DivW+1:0] div_diff;
  logic            div_ge;
  logic [DivW-1:0] div_rem_d;

  assign div_shift = {rem_q, num_q[FreqW-1]};
  assign div_diff  = {1'b0, div_shift} - {2'b00, den_q};
  assign div_ge    = !div_diff[DivW+1];
  assign div_rem_d = div_ge ? div_diff[DivW-1:0] : div_shift[DivW-1:0];

  // product split: count * 256e6 = prod << 11, high word is prod[40:21]
  logic [DivW-1:0]  prod_hi;
  logic [FreqW-1:0] prod_lo;

  assign prod_hi = DivW'(prod_q[ProdW-1:21]);
  assign prod_lo = {prod_q[20:0], 11'b0};

  // per-tick counter update, independent per channel
  logic [ElapW-1:0]       elapsed_d [NumChannels];
  logic signed [RemW-1:0] remain_d  [NumChannels];
  logic [NumChannels-1:0] expired_d;

  always_comb begin
    for (int c = 0; c < NumChannels; c++) begin
      logic [ElapW:0]         e_sum;
      logic signed [RemW:0]   r_diff;
      e_sum  = {1'b0, elapsed_q[c]} + (ElapW+1)'(tick_q);
      r_diff = {remain_q[c][RemW-1], remain_q[c]} - $signed((RemW+1)'(tick_q));
      elapsed_d[c] = elapsed_q[c];
      remain_d[c]  = remain_q[c];
      if (!remain_q[c][RemW-1] && (remain_q[c] != '0)) begin
        elapsed_d[c] = e_sum[ElapW] ? ElapsedMax : e_sum[ElapW-1:0];
        remain_d[c]  = (r_diff < (RemW+1)'(RemainMin)) ? RemainMin : r_diff[RemW-1:0];
      end
      expired_d[c] = remain_d[c][RemW-1] || (remain_d[c] == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ch_q        <= '0;
      tick_q      <= TickReset;
      expired_q   <= '1;
      pend_q      <= '0;
      upd_q       <= '0;
      out_valid_q <= 1'b0;
      out_upd_q   <= '0;
      for (int c = 0; c < NumChannels; c++) begin
        elapsed_q[c]  <= InitUs;
        remain_q[c]   <= RemW'(InitUs);
        gate_q[c]     <= InitUs;
        freq_q[c]     <= '0;
        out_freq_q[c] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        tick_q <= cfg_wdata_i;
      end
      // the tick step refills the output register itself
      if (out_valid_q && out_ch.ready && (state_q != S_TICK)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            for (int c = 0; c < NumChannels; c++) begin
              count_q[c] <= count_in[c];
            end
            pend_q  <= pend_q | restart_in;
            upd_q   <= '0;
            ch_q    <= '0;
            state_q <= S_CHAN;
          end
        end
        S_CHAN: begin
          prod_q <= ProdW'(count_q[ch_q]) * ProdW'(ScaleMul);
          if (!expired_q[ch_q]) begin
            state_q <= last_ch ? S_TICK : S_CHAN;
            ch_q    <= ch_q + 1'b1;
          end else if (pend_q[ch_q]) begin
            // restart: pick a short gate, frequency untouched
            gate_q[ch_q]    <= (gate_q[ch_q] == GateLongUs) ? GateOneUs : GateShortUs;
            remain_q[ch_q]  <= RemW'((gate_q[ch_q] == GateLongUs) ? GateOneUs
                                                                   : GateShortUs);
            elapsed_q[ch_q] <= '0;
            pend_q[ch_q]    <= 1'b0;
            state_q         <= last_ch ? S_TICK : S_CHAN;
            ch_q            <= ch_q + 1'b1;
          end else begin
            state_q <= S_FPREP;
          end
        end
        S_FPREP: begin
          if (count_q[ch_q] == '0) begin
            res_q   <= '0;
            state_q <= S_GPREP;
          end else if (prod_hi >= DivW'(elapsed_q[ch_q])) begin
            // quotient overflows 32 bits, also covers zero elapsed time
            res_q   <= '1;
            state_q <= S_GPREP;
          end else begin
            rem_q   <= prod_hi;
            den_q   <= DivW'(elapsed_q[ch_q]);
            num_q   <= prod_lo;
            quo_q   <= '0;
            cnt_q   <= FreqIters;
            state_q <= S_FDIV;
          end
        end
        S_FDIV, S_GDIV: begin
          rem_q <= div_rem_d;
          num_q <= {num_q[FreqW-2:0], 1'b0};
          quo_q <= {quo_q[FreqW-2:0], div_ge};
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == IterW'(1)) begin
            if (state_q == S_FDIV) begin
              res_q   <= {quo_q[FreqW-2:0], div_ge};
              state_q <= S_GPREP;
            end else begin
              state_q <= S_FIN;
            end
          end
        end
        S_GPREP: begin
          if (res_q <= SlowFreqMax) begin
            quo_q   <= FreqW'(GateLongUs);
            state_q <= S_FIN;
          end else begin
            rem_q   <= GateNumHi;
            den_q   <= DivW'(res_q) + GateBias;
            num_q   <= '0;
            quo_q   <= '0;
            cnt_q   <= GateIters;
            state_q <= S_GDIV;
          end
        end
        S_FIN: begin
          freq_q[ch_q]    <= res_q;
          gate_q[ch_q]    <= quo_q[GateW-1:0];
          remain_q[ch_q]  <= RemW'(quo_q[GateW-1:0]);
          elapsed_q[ch_q] <= '0;
          upd_q[ch_q]     <= 1'b1;
          state_q         <= last_ch ? S_TICK : S_CHAN;
          ch_q            <= ch_q + 1'b1;
        end
        S_TICK: begin
          if (out_free) begin
            for (int c = 0; c < NumChannels; c++) begin
              elapsed_q[c]  <= elapsed_d[c];
              remain_q[c]   <= remain_d[c];
              out_freq_q[c] <= freq_q[c];
            end
            expired_q   <= expired_d;
            out_upd_q   <= upd_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // divider keeps its partial remainder below the divisor
  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FDIV || state_q == S_GDIV) |-> (rem_q < den_q))
    else $error("divider remainder not below divisor");

  a_div_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FDIV || state_q == S_GDIV) |-> (cnt_q != '0))
    else $error("divider running with zero iteration count");

  a_accept_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == S_CHAN && ch_q == '0 && upd_q == '0))
    else $error("item accepted but channel walk did not start");

  a_upd_gated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN) |-> expired_q[ch_q])
    else $error("frequency update on a channel whose gate had not expired");

endmodule
`default_nettype wire
